// ===== rtl/rgb2yuv_pkg.sv =====
package rgb2yuv_pkg;

    localparam int MAX_PAIRS_PER_LINE = 2048;

    localparam int PIX_W  = 8;
    localparam int CNT_W  = 12;
    localparam int SUM_W  = PIX_W + 1;
    localparam int TOT_W  = PIX_W + 2;
    localparam int LINE_W = 3 * SUM_W;

    localparam int ADDR_W = (MAX_PAIRS_PER_LINE > 1) ? $clog2(MAX_PAIRS_PER_LINE) : 1;
    localparam int MAXP_W = $clog2(MAX_PAIRS_PER_LINE + 1);
    localparam int CMP_W  = (CNT_W + 1 > MAXP_W) ? CNT_W + 1 : MAXP_W;

    localparam int DATA_W      = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int REG_SEL_BIT = 2;

    localparam int PAIRS_RESET = 320;
    localparam int ROWS_RESET  = 240;

    typedef enum logic {
        REG_PAIRS_PER_LINE,
        REG_ROW_PAIRS
    } t_reg_idx;

    // luma coefficients, scaled by 1000
    localparam int Y_R      = 257;
    localparam int Y_G      = 504;
    localparam int Y_B      = 98;
    localparam int Y_OFFSET = 16;

    // chroma coefficients on four-pixel sums, scaled by 4000
    localparam int CB_R     = 148;
    localparam int CB_G     = 291;
    localparam int CB_B     = 439;
    localparam int CR_R     = 439;
    localparam int CR_G     = 368;
    localparam int CR_B     = 71;
    localparam int C_OFFSET = 512000;

    localparam int LNUM_W = 18;
    localparam int CNUM_W = 20;
    localparam int CSUM_W = CNUM_W + 1;

    // reciprocal multipliers, exact for the numerator ranges above
    localparam int    LUMA_SHIFT  = 28;
    localparam int    LUMA_DIV    = 1000;
    localparam int    LUMA_RECIP  = ((1 << LUMA_SHIFT) / LUMA_DIV) + 1;
    localparam int    LRCP_W      = 19;
    localparam int    LPROD_W     = LNUM_W + LRCP_W;
    localparam int    CHROMA_SHIFT = 32;
    localparam longint CHROMA_DIV  = 4000;
    localparam longint CHROMA_RECIP = ((64'd1 << CHROMA_SHIFT) / CHROMA_DIV) + 64'd1;
    localparam int    CRCP_W      = 21;
    localparam int    CPROD_W     = CNUM_W + CRCP_W;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [CMP_W-1:0] eff_pairs;
        logic [CNT_W:0]   eff_rows;
    } t_cfg_eff;

    typedef struct packed {
        logic [SUM_W-1:0]  sum_r;
        logic [SUM_W-1:0]  sum_g;
        logic [SUM_W-1:0]  sum_b;
        logic              chroma;
        logic              eof;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
    } t_step;

    typedef struct packed {
        t_pix             pix;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic             chroma;
        logic             eof;
    } t_s1;

    typedef struct packed {
        logic [LNUM_W-1:0] luma_num;
        logic [CNUM_W-1:0] cb_num;
        logic [CNUM_W-1:0] cr_num;
        logic              chroma;
        logic              eof;
    } t_s2;

endpackage

// ===== rtl/rgb2yuv_cfg.sv =====
module rgb2yuv_cfg
    import rgb2yuv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output t_cfg_eff              o_eff
);

    logic [CNT_W-1:0] r_pairs;
    logic [CNT_W-1:0] r_rows;
    t_reg_idx         sel;
    logic             wr;

    assign pready = 1'b1;
    assign sel    = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= CNT_W'(PAIRS_RESET);
            r_rows  <= CNT_W'(ROWS_RESET);
        end else if (wr) begin
            case (sel)
                REG_PAIRS_PER_LINE: r_pairs <= pwdata[CNT_W-1:0];
                REG_ROW_PAIRS:      r_rows  <= pwdata[CNT_W-1:0];
                default:            r_pairs <= r_pairs;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_PAIRS_PER_LINE: prdata = DATA_W'(r_pairs);
            REG_ROW_PAIRS:      prdata = DATA_W'(r_rows);
            default:            prdata = '0;
        endcase
    end

    // zero reads as one, width saturates at the line store depth
    always_comb begin
        if (r_pairs == '0) begin
            o_eff.eff_pairs = CMP_W'(1);
        end else if (CMP_W'(r_pairs) > CMP_W'(MAX_PAIRS_PER_LINE)) begin
            o_eff.eff_pairs = CMP_W'(MAX_PAIRS_PER_LINE);
        end else begin
            o_eff.eff_pairs = CMP_W'(r_pairs);
        end
        if (r_rows == '0) begin
            o_eff.eff_rows = (CNT_W+1)'(1);
        end else begin
            o_eff.eff_rows = (CNT_W+1)'(r_rows);
        end
    end

endmodule

// ===== rtl/rgb2yuv_seq.sv =====
module rgb2yuv_seq
    import rgb2yuv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_pix     i_pix,
    input  t_cfg_eff i_eff,
    output t_step    o_step
);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             r_odd_col, n_odd_col;
    logic             r_odd_row, n_odd_row;
    t_pix             r_left, n_left;

    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_inc;
    logic [CNT_W:0]   row_inc;
    logic             col_last;
    logic             row_last;
    logic             in_store;

    assign col_ext  = CMP_W'(r_col);
    assign col_inc  = col_ext + CMP_W'(1);
    assign row_inc  = (CNT_W+1)'(r_row) + (CNT_W+1)'(1);
    assign col_last = col_inc >= i_eff.eff_pairs;
    assign row_last = row_inc >= i_eff.eff_rows;
    assign in_store = col_ext < CMP_W'(MAX_PAIRS_PER_LINE);

    always_comb begin
        o_step.sum_r  = SUM_W'(r_left.red)   + SUM_W'(i_pix.red);
        o_step.sum_g  = SUM_W'(r_left.green) + SUM_W'(i_pix.green);
        o_step.sum_b  = SUM_W'(r_left.blue)  + SUM_W'(i_pix.blue);
        o_step.chroma = r_odd_col && r_odd_row;
        o_step.eof    = r_odd_col && r_odd_row && col_last && row_last;
        o_step.wr_en  = i_accept && r_odd_col && !r_odd_row && in_store;
        o_step.addr   = col_ext[ADDR_W-1:0];
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_odd_col = r_odd_col;
        n_odd_row = r_odd_row;
        n_left    = r_left;
        if (i_accept) begin
            n_odd_col = !r_odd_col;
            if (!r_odd_col) begin
                n_left = i_pix;
            end else if (col_last) begin
                n_col     = '0;
                n_odd_row = !r_odd_row;
                if (r_odd_row) begin
                    n_row = row_last ? '0 : row_inc[CNT_W-1:0];
                end
            end else begin
                n_col = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_odd_col <= 1'b0;
            r_odd_row <= 1'b0;
            r_left    <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_odd_col <= n_odd_col;
            r_odd_row <= n_odd_row;
            r_left    <= n_left;
        end
    end

endmodule

// ===== rtl/rgb2yuv_line_mem.sv =====
module rgb2yuv_line_mem
    import rgb2yuv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [LINE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [LINE_W-1:0] o_rd_data
);

    logic [LINE_W-1:0] r_mem [MAX_PAIRS_PER_LINE];
    logic [LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rgb2yuv_calc.sv =====
module rgb2yuv_calc
    import rgb2yuv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_pix              i_pix,
    input  t_step             i_step,
    input  logic [LINE_W-1:0] i_held,
    input  logic              i_out_stall,
    output logic              o_accept,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output logic [PIX_W-1:0]  o_luma,
    output logic              o_chroma_valid,
    output logic [PIX_W-1:0]  o_chroma_blue,
    output logic [PIX_W-1:0]  o_chroma_red,
    output logic              o_end_of_frame
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;

    logic [PIX_W-1:0] r_luma, n_luma;
    logic             r_chroma, r_eof;
    logic [PIX_W-1:0] r_cb, n_cb;
    logic [PIX_W-1:0] r_cr, n_cr;

    logic [TOT_W-1:0]  tr, tg, tb;
    logic [CSUM_W-1:0] cb_pos, cb_neg, cr_pos, cr_neg, cb_dif, cr_dif;
    logic [LPROD_W-1:0] luma_prod;
    logic [CPROD_W-1:0] cb_prod, cr_prod;

    assign en3        = !r_v3 || !i_out_stall;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_accept   = i_in_valid && en1;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_comb begin
        n_s1.pix    = i_pix;
        n_s1.sum_r  = i_step.sum_r;
        n_s1.sum_g  = i_step.sum_g;
        n_s1.sum_b  = i_step.sum_b;
        n_s1.chroma = i_step.chroma;
        n_s1.eof    = i_step.eof;
    end

    // four-pixel sums and weighted numerators
    always_comb begin
        tr = TOT_W'(r_s1.sum_r) + TOT_W'(i_held[3*SUM_W-1:2*SUM_W]);
        tg = TOT_W'(r_s1.sum_g) + TOT_W'(i_held[2*SUM_W-1:SUM_W]);
        tb = TOT_W'(r_s1.sum_b) + TOT_W'(i_held[SUM_W-1:0]);

        cb_pos = CSUM_W'(tb) * CSUM_W'(CB_B) + CSUM_W'(C_OFFSET);
        cb_neg = CSUM_W'(tr) * CSUM_W'(CB_R) + CSUM_W'(tg) * CSUM_W'(CB_G);
        cr_pos = CSUM_W'(tr) * CSUM_W'(CR_R) + CSUM_W'(C_OFFSET);
        cr_neg = CSUM_W'(tg) * CSUM_W'(CR_G) + CSUM_W'(tb) * CSUM_W'(CR_B);
        cb_dif = cb_pos - cb_neg;
        cr_dif = cr_pos - cr_neg;

        n_s2.luma_num = LNUM_W'(r_s1.pix.red)   * LNUM_W'(Y_R)
                      + LNUM_W'(r_s1.pix.green) * LNUM_W'(Y_G)
                      + LNUM_W'(r_s1.pix.blue)  * LNUM_W'(Y_B);
        n_s2.cb_num   = cb_dif[CNUM_W-1:0];
        n_s2.cr_num   = cr_dif[CNUM_W-1:0];
        n_s2.chroma   = r_s1.chroma;
        n_s2.eof      = r_s1.eof;
    end

    // constant division by reciprocal multiply
    always_comb begin
        luma_prod = LPROD_W'(r_s2.luma_num) * LPROD_W'(LUMA_RECIP);
        cb_prod   = CPROD_W'(r_s2.cb_num) * CPROD_W'(CHROMA_RECIP);
        cr_prod   = CPROD_W'(r_s2.cr_num) * CPROD_W'(CHROMA_RECIP);
        n_luma    = luma_prod[LUMA_SHIFT +: PIX_W] + PIX_W'(Y_OFFSET);
        n_cb      = r_s2.chroma ? cb_prod[CHROMA_SHIFT +: PIX_W] : '0;
        n_cr      = r_s2.chroma ? cr_prod[CHROMA_SHIFT +: PIX_W] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_luma   <= n_luma;
            r_cb     <= n_cb;
            r_cr     <= n_cr;
            r_chroma <= r_s2.chroma;
            r_eof    <= r_s2.eof;
        end
    end

    assign o_out_valid    = r_v3;
    assign o_luma         = r_luma;
    assign o_chroma_valid = r_chroma;
    assign o_chroma_blue  = r_cb;
    assign o_chroma_red   = r_cr;
    assign o_end_of_frame = r_eof;

endmodule

// ===== rtl/rgb_to_yuv420_converter.sv =====
// path: an accepted word passes the s1, s2 and output registers to the output
// throughput: one pixel per clock while the output is free; the three-stage
// pipeline and the line store read set this; a stage moves when the next is free
// reset: synchronous active low; clears the pipeline, position counters, pixel hold
// and registers (320 pairs per line, 240 row pairs); the line store is not cleared
module rgb_to_yuv420_converter
    import rgb2yuv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_luma,
    output logic                  o_chroma_valid,
    output logic [PIX_W-1:0]      o_chroma_blue,
    output logic [PIX_W-1:0]      o_chroma_red,
    output logic                  o_end_of_frame,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    t_pix              pix;
    t_cfg_eff          eff;
    t_step             step;
    logic              accept;
    logic [LINE_W-1:0] held;

    assign pix.red   = i_red;
    assign pix.green = i_green;
    assign pix.blue  = i_blue;

    rgb2yuv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_eff   (eff)
    );

    rgb2yuv_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pix    (pix),
        .i_eff    (eff),
        .o_step   (step)
    );

    rgb2yuv_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (step.wr_en),
        .i_wr_addr (step.addr),
        .i_wr_data ({step.sum_r, step.sum_g, step.sum_b}),
        .i_rd_en   (accept),
        .i_rd_addr (step.addr),
        .o_rd_data (held)
    );

    rgb2yuv_calc u_calc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_pix          (pix),
        .i_step         (step),
        .i_held         (held),
        .i_out_stall    (i_out_stall),
        .o_accept       (accept),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_blue  (o_chroma_blue),
        .o_chroma_red   (o_chroma_red),
        .o_end_of_frame (o_end_of_frame)
    );

    a_eof_on_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_chroma_valid)
        else $error("end of frame without a completed block");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while the output is free");

    a_no_write_on_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.wr_en |-> !step.chroma)
        else $error("line store written on an odd row");

endmodule

// ===== tb/rgb_to_yuv420_converter_test.sv =====
module rgb_to_yuv420_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2yuv_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             end_of_frame;
    } t_yuv_word;

    localparam t_pix PX_BLACK   = 24'h000000;
    localparam t_pix PX_WHITE   = 24'hFFFFFF;
    localparam t_pix PX_RED     = 24'hFF0000;
    localparam t_pix PX_BLUE    = 24'h0000FF;
    localparam t_pix PX_YELLOW  = 24'hFFFF00;
    localparam t_pix PX_CYAN    = 24'h00FFFF;
    localparam int   TAIL_WAIT  = 10;

    class yuv420_scoreboard;
        logic [LINE_W-1:0] pair_sums [MAX_PAIRS_PER_LINE];
        bit                stored [MAX_PAIRS_PER_LINE];
        t_pix              left_pix;
        logic [CNT_W-1:0]  col_idx;
        logic [CNT_W-1:0]  row_idx;
        logic [CNT_W-1:0]  pairs_reg;
        logic [CNT_W-1:0]  rows_reg;
        bit                odd_col;
        bit                odd_row;
        t_yuv_word         expected [$];
        int                errors;

        function new();
            left_pix = '0;
            col_idx = '0;
            row_idx = '0;
            odd_col = 1'b0;
            odd_row = 1'b0;
            pairs_reg = CNT_W'(PAIRS_RESET);
            rows_reg = CNT_W'(ROWS_RESET);
            errors = 0;
            foreach (stored[i]) stored[i] = 1'b0;
        endfunction

        function int line_pairs(logic [CNT_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_PAIRS_PER_LINE) return MAX_PAIRS_PER_LINE;
            return int'(v);
        endfunction

        function int frame_rows();
            return (rows_reg == 0) ? 1 : int'(rows_reg);
        endfunction

        // on an odd row every column still to be read must hold stored sums
        function bit pairs_change_safe(logic [CNT_W-1:0] v);
            int last;
            if (!odd_row) return 1'b1;
            last = (int'(col_idx) + 1 >= line_pairs(v)) ? int'(col_idx) : line_pairs(v) - 1;
            for (int c = int'(col_idx); c <= last; c++) begin
                if (!stored[ADDR_W'(c)]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CNT_W-1:0] v);
            if (idx == REG_PAIRS_PER_LINE) begin
                pairs_reg = v;
            end else begin
                rows_reg = v;
            end
        endfunction

        function void note_pixel(t_pix px);
            t_yuv_word w;
            int sr, sg, sb, tr, tg, tb, ncb, ncr;
            w = '0;
            w.luma = PIX_W'((257 * int'(px.red) + 504 * int'(px.green)
                             + 98 * int'(px.blue)) / 1000 + 16);
            if (!odd_col) begin
                left_pix = px;
            end else begin
                sr = int'(left_pix.red) + int'(px.red);
                sg = int'(left_pix.green) + int'(px.green);
                sb = int'(left_pix.blue) + int'(px.blue);
                if (!odd_row) begin
                    pair_sums[col_idx[ADDR_W-1:0]] = {SUM_W'(sr), SUM_W'(sg), SUM_W'(sb)};
                    stored[col_idx[ADDR_W-1:0]] = 1'b1;
                end else begin
                    tr = sr + int'(pair_sums[col_idx[ADDR_W-1:0]][3*SUM_W-1:2*SUM_W]);
                    tg = sg + int'(pair_sums[col_idx[ADDR_W-1:0]][2*SUM_W-1:SUM_W]);
                    tb = sb + int'(pair_sums[col_idx[ADDR_W-1:0]][SUM_W-1:0]);
                    ncb = -148 * tr - 291 * tg + 439 * tb + 512000;
                    ncr = 439 * tr - 368 * tg - 71 * tb + 512000;
                    w.chroma_valid = 1'b1;
                    w.chroma_blue = PIX_W'(ncb / 4000);
                    w.chroma_red = PIX_W'(ncr / 4000);
                end
                if (int'(col_idx) + 1 >= line_pairs(pairs_reg)) begin
                    col_idx = '0;
                    if (odd_row) begin
                        if (int'(row_idx) + 1 >= frame_rows()) begin
                            row_idx = '0;
                            w.end_of_frame = 1'b1;
                        end else begin
                            row_idx = row_idx + 1'b1;
                        end
                    end
                    odd_row = !odd_row;
                end else begin
                    col_idx = col_idx + 1'b1;
                end
            end
            odd_col = !odd_col;
            expected.push_back(w);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_word(t_yuv_word got);
            t_yuv_word want;
            if (expected.size() == 0) begin
                report($sformatf("word with nothing pending, luma %0d", got.luma));
                return;
            end
            want = expected.pop_front();
            if (got.luma !== want.luma)
                report($sformatf("luma %0d, want %0d", got.luma, want.luma));
            if (got.chroma_valid !== want.chroma_valid)
                report($sformatf("chroma_valid %0b, want %0b",
                                 got.chroma_valid, want.chroma_valid));
            if (got.chroma_blue !== want.chroma_blue)
                report($sformatf("chroma_blue %0d, want %0d",
                                 got.chroma_blue, want.chroma_blue));
            if (got.chroma_red !== want.chroma_red)
                report($sformatf("chroma_red %0d, want %0d", got.chroma_red, want.chroma_red));
            if (got.end_of_frame !== want.end_of_frame)
                report($sformatf("end_of_frame %0b, want %0b",
                                 got.end_of_frame, want.end_of_frame));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_red = '0;
    logic [PIX_W-1:0]      i_green = '0;
    logic [PIX_W-1:0]      i_blue = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIX_W-1:0]      o_luma;
    logic                  o_chroma_valid;
    logic [PIX_W-1:0]      o_chroma_blue;
    logic [PIX_W-1:0]      o_chroma_red;
    logic                  o_end_of_frame;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    yuv420_scoreboard sb;
    bit               pressure = 1'b0;
    int               stall_left = 0;
    int               stall_len;
    t_yuv_word        seen_word;

    rgb_to_yuv420_converter i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int pick;
        if (!pressure) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] random_channel();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CNT_W-1:0] pick_reg_value(bit rows);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return '0;
        if (pick < 22) return CNT_W'(1);
        if (pick < 25) return 12'hFFF;
        return CNT_W'($urandom_range(2, rows ? 4 : 8));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_word = {o_luma, o_chroma_valid, o_chroma_blue, o_chroma_red, o_end_of_frame};
            sb.check_word(seen_word);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_len = idle_len();
            if (stall_len > 0) begin
                stall_left = stall_len - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_pixel(t_pix px, bit park);
        int gap;
        gap = idle_len();
        i_in_valid <= 1'b1;
        i_red <= px.red;
        i_green <= px.green;
        i_blue <= px.blue;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(px);
        if (park || gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        while (sb.expected.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic read_check(t_reg_idx idx, logic [CNT_W-1:0] want);
        logic [DATA_W-1:0] rd;
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= CFG_ADDR_W'(idx) << REG_SEL_BIT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (rd !== DATA_W'(want))
            sb.report($sformatf("register %s reads %0d, want %0d", idx.name(), rd, want));
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CNT_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx) << REG_SEL_BIT;
        pwdata <= ($urandom & 32'hFFFF_F000) | DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
        read_check(idx, value);
    endtask

    initial begin
        #20_000_000;
        $display("rgb_to_yuv420_converter verification failed");
        $finish;
    end

    initial begin
        t_pix bars [16];
        t_pix edges [8];
        logic [CNT_W-1:0] value;
        int sent;
        int n;

        bars = '{PX_BLUE, PX_BLUE, PX_RED, PX_RED, PX_BLUE, PX_BLUE, PX_RED, PX_RED,
                 PX_WHITE, PX_WHITE, PX_BLACK, PX_BLACK, PX_WHITE, PX_WHITE, PX_BLACK, PX_BLACK};
        edges = '{PX_YELLOW, PX_YELLOW, PX_YELLOW, PX_YELLOW,
                  PX_CYAN, PX_CYAN, PX_CYAN, PX_CYAN};
        sb = new();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_check(REG_PAIRS_PER_LINE, CNT_W'(PAIRS_RESET));
        read_check(REG_ROW_PAIRS, CNT_W'(ROWS_RESET));

        // 4x4 frame of saturated colors, then zero registers giving 2x2 frames
        write_reg(REG_PAIRS_PER_LINE, CNT_W'(2));
        write_reg(REG_ROW_PAIRS, CNT_W'(2));
        foreach (bars[i]) send_pixel(bars[i], i == 15);
        settle();
        write_reg(REG_PAIRS_PER_LINE, '0);
        write_reg(REG_ROW_PAIRS, '0);
        foreach (edges[i]) send_pixel(edges[i], i == 7);

        sent = 0;
        while (sent < 550) begin
            n = $urandom_range(10, 60);
            settle();
            pressure = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                value = pick_reg_value(1'b0);
                if (sb.pairs_change_safe(value)) write_reg(REG_PAIRS_PER_LINE, value);
            end
            if ($urandom_range(0, 2) != 0) write_reg(REG_ROW_PAIRS, pick_reg_value(1'b1));
            for (int i = 0; i < n; i++)
                send_pixel({random_channel(), random_channel(), random_channel()}, i == n - 1);
            sent += n;
        end

        while (sb.expected.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("rgb_to_yuv420_converter verification clean");
        end else begin
            $display("rgb_to_yuv420_converter verification failed");
        end
        $finish;
    end
endmodule
